>>> hdl/scrolling_text_matrix_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scrolling text matrix engine
// Clocked concurrent checks, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef SCROLLING_TEXT_MATRIX_ENGINE_ASSERT_SVH
`define SCROLLING_TEXT_MATRIX_ENGINE_ASSERT_SVH

// Same-cycle implication
`define STM_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stm check failed: same-cycle implication");

// Next-cycle implication
`define STM_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stm check failed: next-cycle implication");

`endif

>>> hdl/stm_pkg.sv
// ----------------------------------------------------------------------------
// stm_pkg
// Shared constants, font table, glyph helpers and control structs for the
// scrolling text matrix engine.
// ----------------------------------------------------------------------------
`default_nettype none

package stm_pkg;

  // Default geometry
  localparam int TEXT_CHARS_DEF      = 128;
  localparam int DISPLAY_COLUMNS_DEF = 16;

  // Field widths
  localparam int CMD_W  = 1;
  localparam int POS_W  = 7;
  localparam int CODE_W = 8;
  localparam int CIDX_W = 4;
  localparam int PIX_W  = 7;
  localparam int LEN_W  = 8;
  localparam int SUB_W  = 3;

  // Glyph geometry
  localparam int GLYPH_W = 5;
  localparam int GLYPH_H = 7;
  localparam int CELL_W  = 6;
  localparam int GLYPHS  = 31;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FRAME = 1'b1;

  // Character codes recognized by the font
  localparam logic [CODE_W-1:0] ASC_A     = 8'h41;
  localparam logic [CODE_W-1:0] ASC_Z     = 8'h5A;
  localparam logic [CODE_W-1:0] ASC_SPACE = 8'h20;
  localparam logic [CODE_W-1:0] ASC_DOT   = 8'h2E;
  localparam logic [CODE_W-1:0] ASC_BANG  = 8'h21;
  localparam logic [CODE_W-1:0] ASC_QUEST = 8'h3F;
  localparam logic [CODE_W-1:0] ASC_COMMA = 8'h2C;

  // Glyph indexes
  localparam logic [4:0] GL_SPACE = 5'd26;
  localparam logic [4:0] GL_DOT   = 5'd27;
  localparam logic [4:0] GL_BANG  = 5'd28;
  localparam logic [4:0] GL_QUEST = 5'd29;
  localparam logic [4:0] GL_COMMA = 5'd30;
  localparam logic [4:0] GL_NONE  = 5'd31;

  // Glyph rows, top row first; bit 4 is the leftmost column
  localparam logic [GLYPH_W-1:0] FONT_ROWS [0:GLYPHS-1][0:GLYPH_H-1] = '{
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11}, // A
    '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E}, // B
    '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E}, // C
    '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E}, // D
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F}, // E
    '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10}, // F
    '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h13, 5'h11, 5'h0E}, // G
    '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11}, // H
    '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E}, // I
    '{5'h1F, 5'h01, 5'h01, 5'h01, 5'h01, 5'h11, 5'h0E}, // J
    '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11}, // K
    '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F}, // L
    '{5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11}, // M
    '{5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11}, // N
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}, // O
    '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10}, // P
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h13, 5'h0F}, // Q
    '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11}, // R
    '{5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E}, // S
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04}, // T
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E}, // U
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04}, // V
    '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11}, // W
    '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11}, // X
    '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04}, // Y
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F}, // Z
    '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00}, // space
    '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h10}, // period
    '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h00, 5'h10}, // exclamation
    '{5'h1C, 5'h02, 5'h02, 5'h04, 5'h08, 5'h00, 5'h08}, // question
    '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h10, 5'h10}  // comma
  };

  // Controller to datapath commands
  typedef struct packed {
    logic load;         // write one character
    logic frame_start;  // copy scroll window into the column cursor
    logic issue;        // launch one display column
    logic frame_end;    // advance scroll counters
  } stm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic s1_busy;      // a column is still in the pixel stage
    logic issue_ok;     // the pipeline can take another column
  } stm_sts_t;

  // Map a character code to its glyph index
  function automatic logic [4:0] glyph_of(input logic [CODE_W-1:0] code);
    logic [4:0] g;
    if (code inside {[ASC_A:ASC_Z]}) begin
      g = 5'(code - ASC_A);
    end else begin
      case (code)
        ASC_SPACE: g = GL_SPACE;
        ASC_DOT:   g = GL_DOT;
        ASC_BANG:  g = GL_BANG;
        ASC_QUEST: g = GL_QUEST;
        ASC_COMMA: g = GL_COMMA;
        default:   g = GL_NONE;
      endcase
    end
    return g;
  endfunction

  // Gather one glyph column into row bits, bit 0 is the top row
  function automatic logic [PIX_W-1:0] font_column(input logic [4:0] g,
                                                   input logic [SUB_W-1:0] sub);
    logic [PIX_W-1:0] px;
    logic [SUB_W-1:0] bitpos;
    int r;
    bitpos = SUB_W'(GLYPH_W - 1) - sub;
    for (r = 0; r < GLYPH_H; r++) begin
      px[r] = FONT_ROWS[g][r][bitpos];
    end
    return px;
  endfunction

endpackage

`default_nettype wire

>>> hdl/stm_if.sv
// ----------------------------------------------------------------------------
// stm_if
// Valid/ready channel interfaces for the command input and column output.
// ----------------------------------------------------------------------------
`default_nettype none

interface stm_in_if
  import stm_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [POS_W-1:0]  char_position;
  logic [CODE_W-1:0] char_code;

  modport source (output valid, input ready, output command, output char_position,
                  output char_code);
  modport sink   (input valid, output ready, input command, input char_position,
                  input char_code);
endinterface

interface stm_out_if
  import stm_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] column_index;
  logic [PIX_W-1:0]  column_pixels;
  logic              last_column;

  modport source (output valid, input ready, output column_index, output column_pixels,
                  output last_column);
  modport sink   (input valid, output ready, input column_index, input column_pixels,
                  input last_column);
endinterface

`default_nettype wire

>>> hdl/stm_ctrl.sv
// ----------------------------------------------------------------------------
// stm_ctrl
// Command sequencer: accepts input transactions and steps the datapath
// through the display columns of one frame.
// ----------------------------------------------------------------------------
`default_nettype none

module stm_ctrl
  import stm_pkg::*;
#(
  parameter int DISPLAY_COLUMNS = DISPLAY_COLUMNS_DEF,
  parameter int COL_W           = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [CMD_W-1:0]       in_command,
  input  wire stm_sts_t               sts,
  output stm_cmd_t                    cmd,
  output logic [COL_W-1:0]            col
);

  localparam int COL_W_L = 1;

  typedef enum logic [0:0] {ST_IDLE, ST_RUN} state_t;

  state_t state_r, state_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic accept;
  logic last_col;

  // Accept only when idle and the pixel stage has drained
  assign in_ready = (state_r == ST_IDLE) && !sts.s1_busy;
  assign accept   = in_valid && in_ready;
  assign last_col = (col_r == COL_W'(DISPLAY_COLUMNS - 1));
  assign col      = col_r;

  // Decode commands and next state
  always_comb begin
    state_nxt       = state_r;
    col_nxt         = col_r;
    cmd.load        = 1'b0;
    cmd.frame_start = 1'b0;
    cmd.issue       = 1'b0;
    cmd.frame_end   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == CMD_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.frame_start = 1'b1;
            col_nxt         = '0;
            state_nxt       = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (sts.issue_ok) begin
          cmd.issue = 1'b1;
          if (last_col) begin
            cmd.frame_end = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            col_nxt = col_r + COL_W'(COL_W_L);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state and column counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/stm_datapath.sv
// ----------------------------------------------------------------------------
// stm_datapath
// Text store, scroll counters, column cursor, font lookup, frame column
// store and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module stm_datapath
  import stm_pkg::*;
#(
  parameter int TEXT_CHARS      = TEXT_CHARS_DEF,
  parameter int DISPLAY_COLUMNS = DISPLAY_COLUMNS_DEF,
  parameter int COL_W           = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire stm_cmd_t            cmd,
  input  wire logic [COL_W-1:0]    col,
  output stm_sts_t                 sts,
  input  wire logic [POS_W-1:0]    char_position,
  input  wire logic [CODE_W-1:0]   char_code,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [CIDX_W-1:0]        out_column_index,
  output logic [PIX_W-1:0]         out_column_pixels,
  output logic                     out_last_column
);

  localparam int TA_W = (TEXT_CHARS > 1) ? $clog2(TEXT_CHARS) : 1;
  localparam int EP_W = $clog2(DISPLAY_COLUMNS + 1);

  // Text memory
  logic [CODE_W-1:0] text_mem [TEXT_CHARS];
  logic [CODE_W-1:0] rd_data_r;

  // Scroll state
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] win_ch_r, win_ch_nxt;
  logic [SUB_W-1:0] win_sub_r, win_sub_nxt;
  logic [EP_W-1:0]  entry_r, entry_nxt;
  logic [LEN_W-1:0] cur_ch_r, cur_ch_nxt;
  logic [SUB_W-1:0] cur_sub_r, cur_sub_nxt;

  // Frame column store
  logic [PIX_W-1:0] frame_r [DISPLAY_COLUMNS];

  // Pixel stage
  logic             s1_valid_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_text_r;
  logic             s1_blank_r;
  logic [SUB_W-1:0] s1_sub_r;

  // Output register
  logic              out_valid_r;
  logic [CIDX_W-1:0] out_idx_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic              out_last_r;

  logic             pos_ok;
  logic             load_ok;
  logic             clear;
  logic             out_free;
  logic             move;
  logic             col_in_text;
  logic [LEN_W-1:0] adv_ch;
  logic [SUB_W-1:0] adv_sub;
  logic [LEN_W-1:0] step_ch;
  logic [SUB_W-1:0] step_sub;
  logic [LEN_W-1:0] wn_ch;
  logic [SUB_W-1:0] wn_sub;
  logic [EP_W-1:0]  en;
  logic [4:0]       glyph;
  logic [PIX_W-1:0] text_pix;
  logic [PIX_W-1:0] pix;

  // Handshake status
  assign out_free     = !out_valid_r || out_ready;
  assign move         = s1_valid_r && out_free;
  assign sts.s1_busy  = s1_valid_r;
  assign sts.issue_ok = !s1_valid_r || out_free;

  // Load decode: drop positions beyond the store
  assign pos_ok  = (32'(char_position) < TEXT_CHARS);
  assign load_ok = cmd.load && pos_ok;
  assign clear   = load_ok && (char_position == '0);

  // Column falls inside the entered text region
  assign col_in_text = (EP_W'(col) >= entry_r);

  // Advance the window one text column
  always_comb begin
    if (win_sub_r == SUB_W'(CELL_W - 1)) begin
      adv_ch  = win_ch_r + LEN_W'(1);
      adv_sub = '0;
    end else begin
      adv_ch  = win_ch_r;
      adv_sub = win_sub_r + SUB_W'(1);
    end
  end

  // Advance the cursor one text column
  always_comb begin
    if (cur_sub_r == SUB_W'(CELL_W - 1)) begin
      step_ch  = cur_ch_r + LEN_W'(1);
      step_sub = '0;
    end else begin
      step_ch  = cur_ch_r;
      step_sub = cur_sub_r + SUB_W'(1);
    end
  end

  // Scroll counter update at frame end
  always_comb begin
    if (entry_r == '0) begin
      wn_ch  = adv_ch;
      wn_sub = adv_sub;
      en     = entry_r;
    end else begin
      wn_ch  = win_ch_r;
      wn_sub = win_sub_r;
      en     = entry_r - EP_W'(1);
    end
  end

  // Next scroll and cursor state
  always_comb begin
    len_nxt     = len_r;
    win_ch_nxt  = win_ch_r;
    win_sub_nxt = win_sub_r;
    entry_nxt   = entry_r;
    cur_ch_nxt  = cur_ch_r;
    cur_sub_nxt = cur_sub_r;
    if (load_ok) begin
      len_nxt = LEN_W'(char_position) + LEN_W'(1);
      if (clear) begin
        win_ch_nxt  = '0;
        win_sub_nxt = '0;
        entry_nxt   = EP_W'(DISPLAY_COLUMNS);
      end
    end
    if (cmd.frame_start) begin
      cur_ch_nxt  = win_ch_r;
      cur_sub_nxt = win_sub_r;
    end else if (cmd.issue && col_in_text) begin
      cur_ch_nxt  = step_ch;
      cur_sub_nxt = step_sub;
    end
    if (cmd.frame_end) begin
      if (wn_ch >= len_r) begin
        win_ch_nxt  = '0;
        win_sub_nxt = '0;
        entry_nxt   = EP_W'(DISPLAY_COLUMNS);
      end else begin
        win_ch_nxt  = wn_ch;
        win_sub_nxt = wn_sub;
        entry_nxt   = en;
      end
    end
  end

  // Hold scroll and cursor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      win_ch_r  <= '0;
      win_sub_r <= '0;
      entry_r   <= EP_W'(DISPLAY_COLUMNS);
      cur_ch_r  <= '0;
      cur_sub_r <= '0;
    end else begin
      len_r     <= len_nxt;
      win_ch_r  <= win_ch_nxt;
      win_sub_r <= win_sub_nxt;
      entry_r   <= entry_nxt;
      cur_ch_r  <= cur_ch_nxt;
      cur_sub_r <= cur_sub_nxt;
    end
  end

  // Text memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (load_ok) begin
      text_mem[TA_W'(char_position)] <= char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data_r <= text_mem[TA_W'(cur_ch_r)];
    end
  end

  // Pixel stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (cmd.issue) begin
      s1_valid_r <= 1'b1;
    end else if (move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_col_r   <= col;
      s1_text_r  <= col_in_text;
      s1_blank_r <= (cur_ch_r >= len_r) || (cur_sub_r >= SUB_W'(GLYPH_W));
      s1_sub_r   <= cur_sub_r;
    end
  end

  // Font lookup; outside the font and past the text end show blank
  assign glyph    = glyph_of(rd_data_r);
  assign text_pix = (s1_blank_r || (glyph == GL_NONE)) ? '0 : font_column(glyph, s1_sub_r);
  assign pix      = s1_text_r ? text_pix : frame_r[s1_col_r];

  // Frame column store: refresh entered columns, clear on new text
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DISPLAY_COLUMNS; i++) begin
        frame_r[i] <= '0;
      end
    end else if (clear) begin
      for (int i = 0; i < DISPLAY_COLUMNS; i++) begin
        frame_r[i] <= '0;
      end
    end else if (move && s1_text_r) begin
      frame_r[s1_col_r] <= pix;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_idx_r  <= CIDX_W'(s1_col_r);
      out_pix_r  <= pix;
      out_last_r <= (s1_col_r == COL_W'(DISPLAY_COLUMNS - 1));
    end
  end

  assign out_valid         = out_valid_r;
  assign out_column_index  = out_idx_r;
  assign out_column_pixels = out_pix_r;
  assign out_last_column   = out_last_r;

endmodule

`default_nettype wire

>>> hdl/scrolling_text_matrix_engine.sv
// Load transaction: stores one character, no result. Frame transaction: each column
// passes the pixel stage and the output register, one column per cycle while the
// output is ready; the next transaction is accepted once the sequencer is idle and
// the pixel stage has drained. The pace is set by the single column pipeline (text
// memory read, font lookup). Reset clears the scroll counters, text length and frame
// columns; text memory holds no reset value and is valid once written.
// ----------------------------------------------------------------------------
// scrolling_text_matrix_engine
// Scrolling marquee engine for a 7-row LED matrix: loads text characters and
// emits every display column of each scroll frame.
// ----------------------------------------------------------------------------
`default_nettype none

module scrolling_text_matrix_engine
  import stm_pkg::*;
#(
  parameter int TEXT_CHARS      = TEXT_CHARS_DEF,
  parameter int DISPLAY_COLUMNS = DISPLAY_COLUMNS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  stm_in_if.sink     in_ch,
  stm_out_if.source  out_ch
);

  localparam int COL_W = (DISPLAY_COLUMNS > 1) ? $clog2(DISPLAY_COLUMNS) : 1;

  stm_cmd_t         cmd;
  stm_sts_t         sts;
  logic [COL_W-1:0] col;

  // Sequencer
  stm_ctrl #(
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
    .COL_W           (COL_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_command (in_ch.command),
    .sts        (sts),
    .cmd        (cmd),
    .col        (col)
  );

  // Datapath
  stm_datapath #(
    .TEXT_CHARS      (TEXT_CHARS),
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
    .COL_W           (COL_W)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .col               (col),
    .sts               (sts),
    .char_position     (in_ch.char_position),
    .char_code         (in_ch.char_code),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_column_index  (out_ch.column_index),
    .out_column_pixels (out_ch.column_pixels),
    .out_last_column   (out_ch.last_column)
  );

endmodule

`default_nettype wire

>>> hdl/stm_checker.sv
// ----------------------------------------------------------------------------
// stm_checker
// Port-level checks for the scrolling text matrix engine, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scrolling_text_matrix_engine_assert.svh"

module stm_checker
  import stm_pkg::*;
#(
  parameter int DISPLAY_COLUMNS = DISPLAY_COLUMNS_DEF
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic [CMD_W-1:0]  in_command,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [CIDX_W-1:0] out_column_index,
  input wire logic              out_last_column
);

  // Last flag marks exactly the final display column
  `STM_ASSERT_NOW(a_last_flag, out_valid, out_last_column == (out_column_index == CIDX_W'(DISPLAY_COLUMNS - 1)))

  // No new transaction while a frame still has columns to deliver
  `STM_ASSERT_NOW(a_frame_busy, out_valid && !out_last_column, !in_ready)

  // A frame transaction keeps the input closed in the next cycle
  `STM_ASSERT_NEXT(a_frame_start, in_valid && in_ready && (in_command == CMD_FRAME), !in_ready)

  // A load transaction leaves the input open
  `STM_ASSERT_NEXT(a_load_open, in_valid && in_ready && (in_command == CMD_LOAD), in_ready)

  // A stalled column holds
  `STM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_column_index))

endmodule

bind scrolling_text_matrix_engine stm_checker #(
  .DISPLAY_COLUMNS (DISPLAY_COLUMNS)
) u_stm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_command       (in_ch.command),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_column_index (out_ch.column_index),
  .out_last_column  (out_ch.last_column)
);

`default_nettype wire
